FILE: hdl/assert_macros.svh
// Assertion macros shared by the decimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lfd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lfd assertion failed");

`endif

FILE: hdl/lfd_pkg.sv
// Package: configuration register indexes and shared types of the decimator.
`default_nettype none

package lfd_pkg;

	// Configuration port index width and register indexes
	localparam int CFG_INDEX_WIDTH = 2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ALPHA_GAIN = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_STEP = 2'd1;

	// Status of one filter step, from the datapath to the control
	typedef struct packed {
		logic emit;        // result is delivered downstream
		logic update_hist; // last input and phase advance
	} lfd_status_t;

endpackage

`default_nettype wire

FILE: hdl/lfd_core.sv
// Combinational datapath: one-pole low-pass update and phase accumulator carry.
`default_nettype none

module lfd_core #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                            first,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  x,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  last_in,
	input  wire logic signed [SAMPLE_WIDTH-1:0]  last_out,
	input  wire logic        [FRACTION_BITS-1:0] alpha,
	input  wire logic        [FRACTION_BITS-1:0] phase,
	input  wire logic        [FRACTION_BITS:0]   step,
	output logic signed      [SAMPLE_WIDTH-1:0]  y,
	output logic             [FRACTION_BITS-1:0] phase_next,
	output lfd_pkg::lfd_status_t                 status
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int F  = FRACTION_BITS;
	localparam int AW = W + F + 3;
	localparam logic signed [AW-1:0] MASK_F  = {{(AW-F){1'b0}}, {F{1'b1}}};
	localparam logic signed [AW-1:0] MASK_F1 = {{(AW-F-1){1'b0}}, {(F+1){1'b1}}};

	logic signed [F:0]       alpha_s;
	logic signed [F+1:0]     coef_s;
	logic signed [W:0]       in_sum;
	logic signed [W+F+1:0]   prod_out;
	logic signed [W+F+1:0]   prod_in;
	logic signed [W+F:0]     prod_first;
	logic signed [AW-1:0]    acc_rest;
	logic signed [AW-1:0]    acc_first;
	logic signed [AW-1:0]    q_rest;
	logic signed [AW-1:0]    q_first;
	logic        [F+1:0]     phase_sum;

	// Form gain and complement as signed operands
	assign alpha_s = $signed({1'b0, alpha});
	assign coef_s  = $signed({2'b01, {F{1'b0}}} - {2'b00, alpha});
	assign in_sum  = $signed({x[W-1], x}) + $signed({last_in[W-1], last_in});

	// Two products of the recursive update, and the first-sample product
	assign prod_out   = coef_s * last_out;
	assign prod_in    = alpha_s * in_sum;
	assign prod_first = alpha_s * x;

	// Combine: (1-a)*2*last_out + a*(x+last_in)
	assign acc_rest  = $signed({prod_out, 1'b0})
		+ $signed({prod_in[W+F+1], prod_in});
	assign acc_first = $signed({{2{prod_first[W+F]}}, prod_first});

	// Scale down, truncating toward zero
	assign q_rest  = (acc_rest + (acc_rest[AW-1] ? MASK_F1 : '0)) >>> (F + 1);
	assign q_first = (acc_first + (acc_first[AW-1] ? MASK_F : '0)) >>> F;
	assign y = first ? q_first[W-1:0] : q_rest[W-1:0];

	// Advance the phase; carry out of the fraction emits the result
	assign phase_sum  = {2'b00, phase} + {1'b0, step};
	assign phase_next = phase_sum[F-1:0];

	always_comb begin
		status.update_hist = !first;
		status.emit        = first || (|phase_sum[F+1:F]);
	end

endmodule

`default_nettype wire

FILE: hdl/lowpass_fractional_decimator_unit.sv
// Top level: one-pole low-pass filter with fractional-rate decimation.
//
//  port group | dir | handshake          | payload
//  -----------+-----+--------------------+-------------------------------
//  in         | in  | in_valid/in_stall  | in_sample (signed)
//  out        | out | out_valid/out_stall| out_sample (signed)
//  cfg        | in  | cfg_we             | cfg_index, cfg_wdata
//
//  A request is taken per cycle while in_stall is low; an accepted sample passes the input
//  register, then the result register, to out_sample. The recursion closes through the
//  output history register and the two recursive-update products, which sets that rate.
//  Reset clears the filter history, the phase and both handshakes; gain returns to full
//  scale, step to unity. A stalled output holds its request while a dropped (non-emitted)
//  sample still retires, so in_stall rises only when an emitting sample finds the
//  output register full and stalled.
`default_nettype none

module lowpass_fractional_decimator_unit #(
	parameter int SAMPLE_WIDTH  = 16,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [SAMPLE_WIDTH-1:0]         in_sample,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]              out_sample,
	input  wire logic                                   cfg_we,
	input  wire logic        [lfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  wire logic        [FRACTION_BITS:0]          cfg_wdata
);

	localparam int W = SAMPLE_WIDTH;
	localparam int F = FRACTION_BITS;

	logic                  s1_valid_s1;
	logic signed [W-1:0]   sample_s1;
	logic                  out_valid_q;
	logic signed [W-1:0]   out_sample_q;
	logic                  started_q;
	logic signed [W-1:0]   last_out_q;
	logic signed [W-1:0]   last_in_q;
	logic        [F-1:0]   phase_q;
	logic        [F-1:0]   alpha_q;
	logic        [F:0]     step_q;

	logic signed [W-1:0]   y;
	logic        [F-1:0]   phase_next;
	lfd_pkg::lfd_status_t  status;
	logic                  out_free;
	logic                  s1_fire;
	logic                  in_accept;

	// Filter datapath between the input register and the result register
	lfd_core #(
		.SAMPLE_WIDTH (W),
		.FRACTION_BITS(F)
	) u_core (
		.first     (!started_q),
		.x         (sample_s1),
		.last_in   (last_in_q),
		.last_out  (last_out_q),
		.alpha     (alpha_q),
		.phase     (phase_q),
		.step      (step_q),
		.y         (y),
		.phase_next(phase_next),
		.status    (status)
	);

	// Handshake control
	assign out_free  = !out_valid_q || !out_stall;
	assign s1_fire   = s1_valid_s1 && (!status.emit || out_free);
	assign in_stall  = s1_valid_s1 && !s1_fire;
	assign in_accept = in_valid && !in_stall;

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= {F{1'b1}};
			step_q  <= {1'b1, {F{1'b0}}};
		end else if (cfg_we) begin
			case (cfg_index)
				lfd_pkg::REG_ALPHA_GAIN: alpha_q <= cfg_wdata[F-1:0];
				lfd_pkg::REG_PHASE_STEP: step_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register: load on accept, drop once retired
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= in_sample;
		end
	end

	// Advance filter history and phase as each sample retires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			last_out_q <= '0;
			last_in_q  <= '0;
			phase_q    <= '0;
		end else if (s1_fire) begin
			started_q  <= 1'b1;
			last_out_q <= y;
			if (status.update_hist) begin
				last_in_q <= sample_s1;
				phase_q   <= phase_next;
			end
		end
	end

	// Result register: fill with an emitted sample, release when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire && status.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && status.emit) begin
			out_sample_q <= y;
		end
	end

`include "assert_macros.svh"

	`LFD_ASSERT_IMP(a_first_emits, clk, arst_n, s1_valid_s1 && !started_q, status.emit)
	`LFD_ASSERT_NEXT(a_started_sticks, clk, arst_n, started_q, started_q)
	`LFD_ASSERT_IMP(a_zero_step_silent, clk, arst_n,
		s1_valid_s1 && started_q && step_q == '0, !status.emit)
	`LFD_ASSERT_IMP(a_blocked_stalls, clk, arst_n,
		s1_valid_s1 && status.emit && out_valid_q && out_stall, in_stall)

endmodule

`default_nettype wire

FILE: test/lowpass_fractional_decimator_unit_checker.sv
// Checker: watches the decimator channels, predicts each filtered sample and compares.
module lowpass_fractional_decimator_unit_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_stall,
	input  logic signed [15:0]                   in_sample,
	input  logic                                 out_valid,
	input  logic                                 out_stall,
	input  logic signed [15:0]                   out_sample,
	input  logic                                 cfg_we,
	input  logic [lfd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [16:0]                          cfg_wdata,
	output int                                   error_count,
	output int                                   pending_results,
	output int                                   results_seen,
	output int                                   samples_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint UNITY = 64'sd65536;
	localparam int PRINT_CAP = 20;

	// Predicted filter state and register copies
	logic               started;
	logic signed [15:0] last_out;
	logic signed [15:0] last_in;
	logic [15:0]        phase_acc;
	logic [15:0]        alpha_gain;
	logic [16:0]        phase_step;

	logic signed [15:0] filtered_queue[$];
	logic signed [15:0] want;
	logic [17:0]        phase_sum;
	longint             smoothed;

	// One-pole update; truncates toward zero like signed integer division
	function automatic longint lowpass_value(input logic signed [15:0] x);
		longint a;
		a = longint'(alpha_gain);
		if (!started)
			return (a * longint'(x)) / UNITY;
		return ((UNITY - a) * 2 * longint'(last_out) + a * (longint'(x) + longint'(last_in)))
			/ (2 * UNITY);
	endfunction

	// Print the first few faults, count all of them
	task automatic report_fault(input string msg);
		if (error_count < PRINT_CAP)
			$display("[%0t] checker: %s", $realtime, msg);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started = 1'b0;
			last_out = '0;
			last_in = '0;
			phase_acc = '0;
			alpha_gain = 16'hFFFF;
			phase_step = 17'h10000;
			filtered_queue.delete();
			error_count = 0;
			pending_results = 0;
			results_seen = 0;
			samples_seen = 0;
		end else begin
			// Compare a delivered sample with the oldest prediction
			if (out_valid && !out_stall) begin
				if (filtered_queue.size() == 0) begin
					report_fault($sformatf("out_sample %0d with no request pending", out_sample));
				end else begin
					want = filtered_queue.pop_front();
					if (out_sample !== want)
						report_fault($sformatf("out_sample %0d, predicted %0d", out_sample, want));
					results_seen++;
				end
			end
			// Track register writes; spare indexes drop
			if (cfg_we) begin
				case (cfg_index)
					lfd_pkg::REG_ALPHA_GAIN: alpha_gain = cfg_wdata[15:0];
					lfd_pkg::REG_PHASE_STEP: phase_step = cfg_wdata;
					default: ;
				endcase
			end
			// Advance the filter on each accepted request
			if (in_valid && !in_stall) begin
				samples_seen++;
				smoothed = lowpass_value(in_sample);
				if (!started) begin
					started = 1'b1;
					last_out = smoothed[15:0];
					filtered_queue.push_back(smoothed[15:0]);
				end else begin
					phase_sum = {2'b00, phase_acc} + {1'b0, phase_step};
					phase_acc = phase_sum[15:0];
					last_in = in_sample;
					last_out = smoothed[15:0];
					if (phase_sum >= 18'h10000)
						filtered_queue.push_back(smoothed[15:0]);
				end
			end
			pending_results = filtered_queue.size();
		end
	end

endmodule

FILE: test/lowpass_fractional_decimator_unit_test.sv
// Testbench top: drives samples and register writes into the decimator and gives the verdict.
module lowpass_fractional_decimator_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_SAMPLES = 600;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam logic [lfd_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_LOW = 2'd2;
	localparam logic [lfd_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE_HIGH = 2'd3;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                in_valid = 1'b0;
	logic                                in_stall;
	logic signed [15:0]                  in_sample = '0;
	logic                                out_valid;
	logic                                out_stall = 1'b0;
	logic signed [15:0]                  out_sample;
	logic                                cfg_we = 1'b0;
	logic [lfd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [16:0]                         cfg_wdata = '0;

	int error_count;
	int pending_results;
	int results_seen;
	int samples_seen;

	int cycle_count = 0;
	int idle_pct = 12;
	bit steady = 1'b0;
	int hold_asked = 0;
	int hold_taken = 0;
	int hold_left = 0;
	int setting_count = 0;

	lowpass_fractional_decimator_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_sample  (in_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_sample (out_sample),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	lowpass_fractional_decimator_unit_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_sample       (in_sample),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_sample      (out_sample),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.error_count     (error_count),
		.pending_results (pending_results),
		.results_seen    (results_seen),
		.samples_seen    (samples_seen)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, long hold-offs on demand, none while steady
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else if (hold_taken < hold_asked) begin
			hold_taken++;
			hold_left = HOLD_CYCLES - 1;
			out_stall = 1'b1;
		end else begin
			out_stall = !steady && ($urandom_range(99) < 12);
		end
	end

	// Write one register; called at a falling edge
	task automatic set_register(input logic [lfd_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [16:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// Wait for every predicted sample, then let dropped requests drain
	task automatic settle();
		in_valid = 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Offer one sample and hold it until accepted
	task automatic send_sample(input logic signed [15:0] s);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		in_sample = s;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	initial begin
		int phase;
		int count;
		int r;
		int sent;
		logic [15:0] gain;
		logic [16:0] step;
		logic signed [15:0] s;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// First sample after reset with the reset settings, then the range extremes
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
		send_sample(16'sd1);
		send_sample(16'sh7FFF);

		// Spare indexes must leave the settings alone
		settle();
		set_register(REG_SPARE_LOW, 17'h00000);
		set_register(REG_SPARE_HIGH, 17'h1FFFF);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);

		// Zero gain and zero step: nothing comes out
		settle();
		set_register(lfd_pkg::REG_ALPHA_GAIN, 17'h00000);
		set_register(lfd_pkg::REG_PHASE_STEP, 17'h00000);
		setting_count++;
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd5);

		// Full gain, with the unused gain bit set, and the largest step
		settle();
		set_register(lfd_pkg::REG_ALPHA_GAIN, 17'h1FFFF);
		set_register(lfd_pkg::REG_PHASE_STEP, 17'h1FFFF);
		setting_count++;
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd100);
		send_sample(-16'sd100);
		send_sample(16'sh7FFF);

		// Half gain, half rate
		settle();
		set_register(lfd_pkg::REG_ALPHA_GAIN, 17'h08000);
		set_register(lfd_pkg::REG_PHASE_STEP, 17'h08000);
		setting_count++;
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);

		// Random phases: new gain and step each, random sample content
		sent = 0;
		phase = 0;
		while (sent < RANDOM_SAMPLES) begin
			settle();
			r = $urandom_range(99);
			if (r < 15)
				gain = 16'h0000;
			else if (r < 30)
				gain = 16'hFFFF;
			else
				gain = 16'($urandom);
			r = $urandom_range(99);
			if (r < 30 || phase == 1)
				step = 17'h10000;
			else if (r < 60)
				step = 17'($urandom_range(65535, 1));
			else if (r < 75)
				step = 17'($urandom_range(131071, 65537));
			else if (r < 90)
				step = 17'($urandom_range(4096, 1));
			else if (r < 95)
				step = 17'h00000;
			else
				step = 17'h1FFFF;
			if ($urandom_range(4) == 0)
				set_register($urandom_range(1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
					17'($urandom));
			set_register(lfd_pkg::REG_ALPHA_GAIN, {1'($urandom_range(1)), gain});
			set_register(lfd_pkg::REG_PHASE_STEP, step);
			setting_count++;

			// One phase runs with no idling on either side
			steady = (phase == 2);
			idle_pct = steady ? 0 : 12;
			count = $urandom_range(60, 20);
			for (int i = 0; i < count; i++) begin
				// Hold the output long enough to back up the input
				if (phase == 1 && i == 4)
					hold_asked++;
				r = $urandom_range(99);
				if (r < 70)
					s = 16'($urandom);
				else if (r < 80)
					s = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
				else
					s = 16'(int'($urandom_range(200)) - 100);
				send_sample(s);
				sent++;
			end
			phase++;
		end

		// Drain and watch for stray results
		steady = 1'b0;
		in_valid = 1'b0;
		while (pending_results != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);

		$display("Filtered %0d input samples into %0d output samples over %0d gain/step settings,",
			samples_seen, results_seen, setting_count);
		$display("with random idling, %0d long output hold-off(s) and spare-index writes.",
			hold_taken);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
